// ===== sv/mh64_pkg.sv =====
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and control types for the MurmurHash64A stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package mh64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  // multiplier operand sources
  localparam logic [2:0] SRC_LEN   = 3'd0;  // zero-extended message length
  localparam logic [2:0] SRC_WORD  = 3'd1;  // full message word
  localparam logic [2:0] SRC_KMIX  = 3'd2;  // product xor-shifted by 47
  localparam logic [2:0] SRC_HXK   = 3'd3;  // running hash xor product
  localparam logic [2:0] SRC_HTAIL = 3'd4;  // running hash xor masked tail
  localparam logic [2:0] SRC_HFIN  = 3'd5;  // running hash xor-shifted by 47

  // running hash load sources
  localparam logic H_SEL_SEED = 1'b0;  // seed xor product
  localparam logic H_SEL_PROD = 1'b1;  // product

  typedef struct packed {
    logic       load;       // capture input item
    logic       mul_start;
    logic [2:0] mul_src;
    logic       h_load;
    logic       h_sel;
    logic       msg_set;    // message continues
    logic       msg_clear;  // message finished
    logic       out_load;   // capture finished hash
  } dp_cmd_t;

  typedef struct packed {
    logic in_msg;
    logic nb_full;
    logic nb_zero;
    logic last;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/mh64_mul.sv =====
// ----------------------------------------------------------------------------
// mh64_mul
// Iterative 64-bit multiply by MIX_MUL, low 64 bits kept. One 32x32
// multiplier, three partial products accumulated in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic             done,
  output logic [63:0]      product
);
  import mh64_pkg::*;

  logic        busy;
  logic [1:0]  phase;
  logic [63:0] a;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] a_half;
  logic [31:0] m_half;
  logic [63:0] pp;

  always_comb begin
    case (phase)
      2'd0: begin
        a_half = a[31:0];
        m_half = MIX_MUL[31:0];
      end
      2'd1: begin
        a_half = a[31:0];
        m_half = MIX_MUL[63:32];
      end
      default: begin
        a_half = a[63:32];
        m_half = MIX_MUL[31:0];
      end
    endcase
  end

  assign pp = a_half * m_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // cross products only reach the upper half
  always_ff @(posedge clk) begin
    if (start) begin
      a <= operand;
    end else if (busy) begin
      prod <= pp;
      case (phase)
        2'd0: begin
        end
        2'd1: begin
          acc <= prod;
        end
        default: begin
          acc[63:32] <= acc[63:32] + prod[31:0];
        end
      endcase
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// ===== sv/mh64_dp.sv =====
// ----------------------------------------------------------------------------
// mh64_dp
// Datapath: item capture, running hash, operand selection, shared multiplier
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mh64_pkg::dp_cmd_t    cmd,
  output mh64_pkg::dp_status_t      status,
  input  wire logic [63:0]          hash_seed,
  input  wire logic [63:0]          word_data,
  input  wire logic [3:0]           valid_bytes,
  input  wire logic [31:0]          msg_length,
  input  wire logic                 last_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [63:0]               hash_value
);
  import mh64_pkg::*;

  logic [63:0] word_r;
  logic [3:0]  nb_r;
  logic [31:0] len_r;
  logic        last_r;
  logic [63:0] h_r;
  logic        in_msg;
  logic [63:0] p;
  logic        mul_done;
  logic [63:0] operand;
  logic [63:0] tail_mask;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tail_mask[8*b +: 8] = (4'(b) < nb_r) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    case (cmd.mul_src)
      SRC_LEN:   operand = {32'd0, len_r};
      SRC_WORD:  operand = word_r;
      SRC_KMIX:  operand = p ^ (p >> MIX_SHIFT);
      SRC_HXK:   operand = h_r ^ p;
      SRC_HTAIL: operand = h_r ^ (word_r & tail_mask);
      SRC_HFIN:  operand = h_r ^ (h_r >> MIX_SHIFT);
      default:   operand = word_r;
    endcase
  end

  mh64_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .operand (operand),
    .done    (mul_done),
    .product (p)
  );

  // capture item; saturate the byte count at a full word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= word_data;
      nb_r   <= (valid_bytes > WORD_BYTES) ? WORD_BYTES : valid_bytes;
      len_r  <= msg_length;
      last_r <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_r    <= 64'd0;
      in_msg <= 1'b0;
    end else begin
      if (cmd.h_load) begin
        h_r <= (cmd.h_sel == H_SEL_SEED) ? (hash_seed ^ p) : p;
      end
      if (cmd.msg_set) begin
        in_msg <= 1'b1;
      end else if (cmd.msg_clear) begin
        in_msg <= 1'b0;
        h_r    <= 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_value <= p ^ (p >> MIX_SHIFT);
    end
  end

  assign status.in_msg   = in_msg;
  assign status.nb_full  = (nb_r == WORD_BYTES);
  assign status.nb_zero  = (nb_r == 4'd0);
  assign status.last     = last_r;
  assign status.mul_done = mul_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== sv/mh64_ctrl.sv =====
// ----------------------------------------------------------------------------
// mh64_ctrl
// Controller: sequences the multiplies of one item through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output mh64_pkg::dp_cmd_t         cmd,
  input  wire mh64_pkg::dp_status_t status
);
  import mh64_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_LEN   = 4'd2;
  localparam logic [3:0] S_BODY  = 4'd3;
  localparam logic [3:0] S_K1    = 4'd4;
  localparam logic [3:0] S_K2    = 4'd5;
  localparam logic [3:0] S_H     = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.in_msg) begin
          state_next = S_BODY;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_LEN;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        if (status.mul_done) begin
          cmd.h_load = 1'b1;
          cmd.h_sel  = H_SEL_SEED;
          state_next = S_BODY;
        end
      end
      S_BODY: begin
        if (status.nb_full) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_WORD;
          state_next    = S_K1;
        end else if (!status.nb_zero) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_HTAIL;
          state_next    = S_H;
        end else begin
          state_next = S_END;
        end
      end
      S_K1: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_KMIX;
          state_next    = S_K2;
        end
      end
      S_K2: begin
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_HXK;
          state_next    = S_H;
        end
      end
      S_H: begin
        if (status.mul_done) begin
          cmd.h_load = 1'b1;
          cmd.h_sel  = H_SEL_PROD;
          state_next = S_END;
        end
      end
      S_END: begin
        if (status.last) begin
          cmd.mul_start = 1'b1;
          cmd.mul_src   = SRC_HFIN;
          state_next    = S_FIN;
        end else begin
          cmd.msg_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_FIN: begin
        if (status.mul_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        // hold the final product until the output register frees up
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.msg_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/murmur64a_stream_hash_unit.sv =====
// ----------------------------------------------------------------------------
// murmur64a_stream_hash_unit
// MurmurHash64A over a stream of little-endian 64-bit message words.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------------
//   in      | in_valid / in_ready        | word_data, valid_bytes,
//           |                            | msg_length, last_word
//   out     | out_valid / out_ready      | hash_value
//   config  | psel, penable, pwrite ...  | hash_seed at paddr 0x0-0x7
//
// Each 64x64 multiply runs on one shared 32x32 multiplier.
// A middle full word needs three multiplies, a tail word one, an empty none.
// The first word of a message adds the length multiply, the last adds the
// end mix multiply and the output load.
// Reset is synchronous; it clears the controller, message state and out_valid.
// The finished hash waits in the output register; a stall there blocks only
// the end of the next message, not the accepting of its words.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur64a_stream_hash_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] word_data,
  input  wire logic [3:0]  valid_bytes,
  input  wire logic [31:0] msg_length,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  import mh64_pkg::*;

  logic [63:0] hash_seed;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= 64'd0;
    end else if (psel && penable && pwrite && pready && !paddr[3]) begin
      hash_seed <= pwdata;
    end
  end

  assign prdata = paddr[3] ? 64'd0 : hash_seed;

  mh64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  mh64_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .hash_seed   (hash_seed),
    .word_data   (word_data),
    .valid_bytes (valid_bytes),
    .msg_length  (msg_length),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hash_value  (hash_value)
  );

endmodule

`default_nettype wire

// ===== sv/mh64_checker.sv =====
// ----------------------------------------------------------------------------
// mh64_checker
// Port-level checks on the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mh64_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] hash_value
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while busy");

  // a new result only appears at the end of an item's work
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in flight");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind murmur64a_stream_hash_unit mh64_checker u_mh64_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hash_value (hash_value)
);

`default_nettype wire

// ===== dv/mh64_hash_checker.sv =====
// ----------------------------------------------------------------------------
// mh64_hash_checker
// Watches the word, hash and seed-register traffic of the MurmurHash64A
// stream hasher. Each accepted word is folded into a local running hash. On
// the last word of a message the finished hash is queued, and each hash the
// block hands out is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module mh64_hash_checker
  import mh64_pkg::*;
#(
  parameter logic [3:0] SEED_ADDR = 4'h0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] word_data,
  input  logic [3:0]  valid_bytes,
  input  logic [31:0] msg_length,
  input  logic        last_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] hash_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output int          mismatch_count,
  output int          hashes_outstanding
);

  logic [63:0] seed_reg;
  logic [63:0] run_hash;
  logic        in_msg;
  logic [63:0] expected_hashes[$];
  int          errors;

  function automatic logic [63:0] finish_hash(input logic [63:0] h);
    logic [63:0] x;
    x = h ^ (h >> MIX_SHIFT);
    x = x * MIX_MUL;
    return x ^ (x >> MIX_SHIFT);
  endfunction

  initial errors = 0;

  always @(posedge clk) begin : monitor
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] want;
    logic [3:0]  nb;
    if (rst) begin
      seed_reg = '0;
      run_hash = '0;
      in_msg = 1'b0;
      expected_hashes.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
        seed_reg = pwdata;

      if (in_valid && in_ready) begin
        // saturate oversized counts to a full word
        nb = (valid_bytes > WORD_BYTES) ? WORD_BYTES : valid_bytes;
        h = in_msg ? run_hash : (seed_reg ^ ({32'd0, msg_length} * MIX_MUL));
        if (nb == WORD_BYTES) begin
          k = word_data * MIX_MUL;
          k = k ^ (k >> MIX_SHIFT);
          k = k * MIX_MUL;
          h = (h ^ k) * MIX_MUL;
        end else if (nb != 4'd0) begin
          // drop bytes past the valid count
          h = (h ^ (word_data & ((64'd1 << (8 * nb)) - 64'd1))) * MIX_MUL;
        end
        if (last_word) begin
          expected_hashes.push_back(finish_hash(h));
          run_hash = '0;
          in_msg = 1'b0;
        end else begin
          run_hash = h;
          in_msg = 1'b1;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value with no message pending: actual %h", hash_value);
          errors++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_value !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, hash_value);
            errors++;
          end
        end
      end
    end
    hashes_outstanding <= expected_hashes.size();
    mismatch_count <= errors;
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream hasher test: directed messages for the empty message, tail sizes,
// oversized and zero byte counts and short middle words, then random
// messages (mostly well formed, some noise) under several seed values.
// Both channels idle at random and the hash side holds off once for a long
// stretch so the block backs up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import mh64_pkg::*;

  localparam logic [3:0] SEED_ADDR = 4'h0;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 800;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] word_data;
  logic [3:0]  valid_bytes;
  logic [31:0] msg_length;
  logic        last_word;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] hash_value;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int mismatch_count;
  int hashes_outstanding;
  int words_accepted;
  int phase_items;
  int cycle_count;

  murmur64a_stream_hash_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word_data  (word_data),
    .valid_bytes(valid_bytes),
    .msg_length (msg_length),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mh64_hash_checker #(.SEED_ADDR(SEED_ADDR)) u_hash_check (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .word_data         (word_data),
    .valid_bytes       (valid_bytes),
    .msg_length        (msg_length),
    .last_word         (last_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hash_value        (hash_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatch_count    (mismatch_count),
    .hashes_outstanding(hashes_outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic offer_word(input logic [63:0] w, input logic [3:0] nb,
                            input logic [31:0] len, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    word_data   <= w;
    valid_bytes <= nb;
    msg_length  <= len;
    last_word   <= fin;
    do @(posedge clk); while (!in_ready);
    words_accepted++;
    if (nb != 4'd0 || fin) phase_items++;
  endtask

  task automatic write_seed(input logic [63:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= SEED_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle_idle();
    // let the checker count the item accepted at this edge
    @(posedge clk);
    while (hashes_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_message();
    int unsigned nbytes;
    int unsigned nfull;
    int unsigned ntail;
    int unsigned n;
    if ($urandom_range(0, 99) < 80) begin
      // well-formed message, length matches the bytes sent
      nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 160)
                                            : $urandom_range(0, 40);
      nfull = nbytes / 8;
      ntail = nbytes % 8;
      if (nbytes == 0)
        offer_word(rand_word(), 4'd0, 32'd0, 1'b1);
      for (int i = 0; i < nfull; i++)
        offer_word(rand_word(), WORD_BYTES, (i == 0) ? nbytes : $urandom,
                   (ntail == 0) && (i == nfull - 1));
      if (ntail != 0)
        offer_word(rand_word(), ntail[3:0], (nfull == 0) ? nbytes : $urandom, 1'b1);
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        offer_word(rand_word(), 4'($urandom_range(0, 15)), $urandom, i == n - 1);
    end
  endtask

  // hash side: random stalls, and one long hold-off to back the block up
  initial begin : hash_sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!hold_done && words_accepted >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(30, 80)) @(posedge clk);
        else
          repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin : word_source
    logic [63:0] seeds[4];
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    word_data   <= '0;
    valid_bytes <= '0;
    msg_length  <= '0;
    last_word   <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    words_accepted = 0;
    phase_items = 0;
    cycle_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed messages under the reset seed
    offer_word('0, 4'd0, 32'd0, 1'b1);                  // empty message
    offer_word('1, 4'd0, 32'hffff_ffff, 1'b1);          // empty, max length
    offer_word('1, 4'd8, 32'd8, 1'b1);
    offer_word('0, 4'd8, 32'd8, 1'b1);
    offer_word('1, 4'd1, 32'd1, 1'b1);                  // garbage above byte 0
    for (int nb = 2; nb <= 7; nb++)
      offer_word('1, nb[3:0], nb, 1'b1);
    offer_word(rand_word(), 4'd15, 32'd8, 1'b1);        // count saturates
    // full word, ignored word, short middle word, tail
    offer_word(64'h0123_4567_89ab_cdef, 4'd8, 32'd20, 1'b0);
    offer_word('1, 4'd0, 32'hffff_ffff, 1'b0);
    offer_word(64'hfedc_ba98_7654_3210, 4'd3, 32'd0, 1'b0);
    offer_word(64'h8000_0000_0000_0001, 4'd4, 32'd0, 1'b1);
    // length disagrees with bytes, ends on a zero-byte word
    offer_word(64'h5555_aaaa_5555_aaaa, 4'd9, 32'd3, 1'b0);
    offer_word('1, 4'd0, 32'd0, 1'b1);
    in_valid <= 1'b0;
    settle_idle();

    seeds[0] = '1;
    seeds[1] = 64'h8000_0000_0000_0000;
    seeds[2] = '0;
    seeds[3] = {$urandom, $urandom};
    for (int p = 0; p < 6; p++) begin
      write_seed((p < 4) ? seeds[p] : {$urandom, $urandom});
      phase_items = 0;
      offer_word(rand_word(), 4'd0, $urandom, 1'b1);
      while (phase_items < PHASE_ITEMS) send_message();
      in_valid <= 1'b0;
      settle_idle();
    end

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
